// ----- src/cbp_pkg.sv -----
package cbp_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    // Each double round is a column half and a diagonal half, each split in two stages.
    localparam int NUM_STAGES    = 4 * DOUBLE_ROUNDS;

    typedef logic [15:0][31:0] t_words;

    typedef struct packed {
        logic [63:0] in_words_0_1;
        logic [63:0] in_words_2_3;
        logic [63:0] in_words_4_5;
        logic [63:0] in_words_6_7;
        logic [63:0] in_words_8_9;
        logic [63:0] in_words_10_11;
        logic [63:0] in_words_12_13;
        logic [63:0] in_words_14_15;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_words_0_1;
        logic [63:0] out_words_2_3;
        logic [63:0] out_words_4_5;
        logic [63:0] out_words_6_7;
        logic [63:0] out_words_8_9;
        logic [63:0] out_words_10_11;
        logic [63:0] out_words_12_13;
        logic [63:0] out_words_14_15;
    } t_out_item;

    typedef struct packed {
        logic diag;   // mix diagonals instead of columns
        logic part;   // second half of the quarter round (rotates 8 and 7)
    } t_stage_ctl;

endpackage

// ----- src/cbp_stage.sv -----
module cbp_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbp_pkg::t_stage_ctl i_ctl,
    input  logic               i_valid,
    input  cbp_pkg::t_words    i_words,
    output logic               o_valid,
    output cbp_pkg::t_words    o_words
);
    import cbp_pkg::*;

    logic   r_valid;
    t_words r_words;
    t_words n_words;

    always_comb begin
        logic [1:0]  qb;
        logic [1:0]  qc;
        logic [1:0]  qd;
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        n_words = i_words;
        for (int q = 0; q < 4; q++) begin
            // diagonals shift rows 1..3 by one, two and three lanes
            qb = 2'(q) + {1'b0, i_ctl.diag};
            qc = 2'(q) + {i_ctl.diag, 1'b0};
            qd = 2'(q) + {i_ctl.diag, i_ctl.diag};
            ia = {2'b00, 2'(q)};
            ib = {2'b01, qb};
            ic = {2'b10, qc};
            id = {2'b11, qd};
            a  = i_words[ia];
            b  = i_words[ib];
            c  = i_words[ic];
            d  = i_words[id];
            if (!i_ctl.part) begin
                a = a + b;
                d = d ^ a;
                d = {d[15:0], d[31:16]};
                c = c + d;
                b = b ^ c;
                b = {b[19:0], b[31:20]};
            end else begin
                a = a + b;
                d = d ^ a;
                d = {d[23:0], d[31:24]};
                c = c + d;
                b = b ^ c;
                b = {b[24:0], b[31:25]};
            end
            n_words[ia] = a;
            n_words[ib] = b;
            n_words[ic] = c;
            n_words[id] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // hold data when no beat passes
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_words <= n_words;
        end
    end

    assign o_valid = r_valid;
    assign o_words = r_words;

endmodule

// ----- src/chacha_block_permutation.sv -----
// Throughput: one block per cycle; each stage runs half of a quarter round on
// four lanes, two dependent 32-bit adds per stage.
// busy stays low: the pipeline never stalls and the receiver cannot hold results off.
// Reset (synchronous, active low) clears every stage valid bit; data is not reset.
module chacha_block_permutation (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cbp_pkg::t_in_item i_data,
    output logic              o_valid,
    output cbp_pkg::t_out_item o_data
);
    import cbp_pkg::*;

    logic       s_valid [0:NUM_STAGES];
    t_words     s_words [0:NUM_STAGES];
    t_stage_ctl w_ctl   [0:NUM_STAGES-1];

    assign busy = 1'b0;

    assign s_valid[0] = start && !busy;
    assign s_words[0] = {
        i_data.in_words_14_15, i_data.in_words_12_13,
        i_data.in_words_10_11, i_data.in_words_8_9,
        i_data.in_words_6_7,   i_data.in_words_4_5,
        i_data.in_words_2_3,   i_data.in_words_0_1
    };

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        assign w_ctl[g].diag = ((g % 4) >= 2) ? 1'b1 : 1'b0;
        assign w_ctl[g].part = ((g % 2) == 1) ? 1'b1 : 1'b0;

        cbp_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_valid (s_valid[g]),
            .i_words (s_words[g]),
            .o_valid (s_valid[g+1]),
            .o_words (s_words[g+1])
        );
    end

    assign o_valid                = s_valid[NUM_STAGES];
    assign o_data.out_words_0_1   = {s_words[NUM_STAGES][1],  s_words[NUM_STAGES][0]};
    assign o_data.out_words_2_3   = {s_words[NUM_STAGES][3],  s_words[NUM_STAGES][2]};
    assign o_data.out_words_4_5   = {s_words[NUM_STAGES][5],  s_words[NUM_STAGES][4]};
    assign o_data.out_words_6_7   = {s_words[NUM_STAGES][7],  s_words[NUM_STAGES][6]};
    assign o_data.out_words_8_9   = {s_words[NUM_STAGES][9],  s_words[NUM_STAGES][8]};
    assign o_data.out_words_10_11 = {s_words[NUM_STAGES][11], s_words[NUM_STAGES][10]};
    assign o_data.out_words_12_13 = {s_words[NUM_STAGES][13], s_words[NUM_STAGES][12]};
    assign o_data.out_words_14_15 = {s_words[NUM_STAGES][15], s_words[NUM_STAGES][14]};

    a_accept_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##NUM_STAGES o_valid)
        else $error("accepted beat did not reach the output on time");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_mid_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_valid[NUM_STAGES/2])
        else $error("pipeline valid bit survived reset");

endmodule
